// ===== hw/rtl/assert_macros.svh =====
// Assertion macros, clocked on clk with asynchronous active-low reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== hw/rtl/sha1s_pkg.sv =====
package sha1s_pkg;
    typedef logic [31:0] word_t;
    typedef word_t [15:0] block_t;
    typedef word_t [4:0] hash_t;

    localparam hash_t IV = '{32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                             32'hefcdab89, 32'h67452301};
    localparam word_t K0 = 32'h5a827999;
    localparam word_t K1 = 32'h6ed9eba1;
    localparam word_t K2 = 32'h8f1bbcdc;
    localparam word_t K3 = 32'hca62c1d6;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam int ROUNDS = 80;

    function automatic word_t rotl(input word_t x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction
endpackage

// ===== hw/rtl/sha1_stream_hasher_core.sv =====
// SHA-1 stream hasher, one byte packed per cycle into a 64-byte block, held
// while a full block is compressed. A word is taken while idle, then its
// valid bytes (at most four) are packed in turn. A last word adds padding
// (one byte a cycle, held during compression) plus one or two compressions,
// then five digest words. Throughput is set by the single round unit.
// Reset (async, rst_n low) loads the initial hash and clears the length.
module sha1_stream_hasher_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha1s_pkg::*;

    typedef enum logic [2:0] {T_IDLE, T_BYTES, T_PAD, T_COMP, T_OUT} tstate_t;

    tstate_t     state_reg;
    tstate_t     ret_reg;
    logic [31:0] data_reg;
    logic [2:0]  cnt_reg;
    logic        last_reg;
    logic [5:0]  pos_reg;
    logic [60:0] len_reg;
    logic        mark_reg;
    logic        lph_reg;
    logic [2:0]  lb_reg;
    logic        started_reg;
    logic [2:0]  idx_reg;
    block_t      blk_reg;
    logic        start;
    logic        init;
    logic        busy;
    hash_t       hash;
    logic        put_en;
    logic [7:0]  put_byte;
    logic [63:0] len_bits;
    logic [2:0]  cnt_in;

    sha1s_round u_round
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .init  (init),
        .blk   (blk_reg),
        .busy  (busy),
        .hash  (hash)
    );

    assign len_bits = {len_reg, 3'b000};
    assign cnt_in   = (byte_count > 3'd4) ? 3'd4 : byte_count;
    assign in_stall = (state_reg != T_IDLE);
    assign start    = (state_reg == T_COMP) && !started_reg;
    assign init     = (state_reg == T_OUT) && (idx_reg == 3'd4) && (!out_valid || !out_stall);

    always_comb
    begin
        put_en   = 1'b0;
        put_byte = '0;
        case (state_reg)
            T_BYTES:
            begin
                put_en   = 1'b1;
                put_byte = data_reg[31:24];
            end
            T_PAD:
            begin
                put_en = 1'b1;
                if (!mark_reg)
                begin
                    put_byte = PAD_MARK;
                end
                else if (!lph_reg && pos_reg != 6'd56)
                begin
                    put_byte = '0;
                end
                else
                begin
                    put_byte = len_bits[{~lb_reg, 3'b000} +: 8];
                end
            end
            default:
            begin
                put_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (put_en)
        begin
            blk_reg[pos_reg[5:2]][{~pos_reg[1:0], 3'b000} +: 8] <= put_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= T_IDLE;
            ret_reg     <= T_IDLE;
            pos_reg     <= '0;
            len_reg     <= '0;
            cnt_reg     <= '0;
            last_reg    <= 1'b0;
            mark_reg    <= 1'b0;
            lph_reg     <= 1'b0;
            lb_reg      <= '0;
            started_reg <= 1'b0;
            idx_reg     <= '0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall && state_reg != T_OUT)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (in_valid)
                    begin
                        data_reg <= data_word;
                        cnt_reg  <= cnt_in;
                        last_reg <= last;
                        mark_reg <= 1'b0;
                        lph_reg  <= 1'b0;
                        lb_reg   <= '0;
                        if (cnt_in != 3'd0)
                        begin
                            state_reg <= T_BYTES;
                        end
                        else if (last)
                        begin
                            state_reg <= T_PAD;
                        end
                    end
                end
                T_BYTES:
                begin
                    data_reg <= {data_reg[23:0], 8'h00};
                    cnt_reg  <= cnt_reg - 3'd1;
                    len_reg  <= len_reg + 61'd1;
                    pos_reg  <= pos_reg + 6'd1;
                    if (pos_reg == 6'd63)
                    begin
                        started_reg <= 1'b0;
                        state_reg   <= T_COMP;
                        if (cnt_reg != 3'd1)
                        begin
                            ret_reg <= T_BYTES;
                        end
                        else
                        begin
                            ret_reg <= last_reg ? T_PAD : T_IDLE;
                        end
                    end
                    else if (cnt_reg == 3'd1)
                    begin
                        state_reg <= last_reg ? T_PAD : T_IDLE;
                    end
                end
                T_PAD:
                begin
                    pos_reg <= pos_reg + 6'd1;
                    if (!mark_reg)
                    begin
                        mark_reg <= 1'b1;
                    end
                    else if (lph_reg || pos_reg == 6'd56)
                    begin
                        lph_reg <= 1'b1;
                        lb_reg  <= lb_reg + 3'd1;
                    end
                    if (pos_reg == 6'd63)
                    begin
                        started_reg <= 1'b0;
                        state_reg   <= T_COMP;
                        ret_reg     <= (lph_reg && lb_reg == 3'd7) ? T_OUT : T_PAD;
                        idx_reg     <= '0;
                    end
                end
                T_COMP:
                begin
                    if (!started_reg)
                    begin
                        started_reg <= 1'b1;
                    end
                    else if (!busy)
                    begin
                        state_reg <= ret_reg;
                    end
                end
                T_OUT:
                begin
                    if (!out_valid || !out_stall)
                    begin
                        out_valid   <= 1'b1;
                        digest_word <= hash[idx_reg];
                        word_index  <= idx_reg;
                        last_word   <= (idx_reg == 3'd4);
                        idx_reg     <= idx_reg + 3'd1;
                        if (idx_reg == 3'd4)
                        begin
                            len_reg   <= '0;
                            state_reg <= T_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== hw/rtl/sha1s_round.sv =====
`include "assert_macros.svh"
module sha1s_round
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             init,
    input  sha1s_pkg::block_t blk,
    output logic             busy,
    output sha1s_pkg::hash_t hash
);
    import sha1s_pkg::*;

    typedef enum logic [1:0] {R_IDLE, R_RUN, R_ADD} rstate_t;

    rstate_t    state_reg;
    logic [6:0] t_reg;
    hash_t      h_reg;
    hash_t      v_reg;
    block_t     w_reg;
    word_t      f;
    word_t      k;
    word_t      wn;
    word_t      tmp;

    always_comb
    begin
        wn = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
        if (t_reg < 7'd20)
        begin
            f = (v_reg[1] & v_reg[2]) | (~v_reg[1] & v_reg[3]);
            k = K0;
        end
        else if (t_reg < 7'd40)
        begin
            f = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k = K1;
        end
        else if (t_reg < 7'd60)
        begin
            f = (v_reg[1] & v_reg[2]) | (v_reg[1] & v_reg[3]) | (v_reg[2] & v_reg[3]);
            k = K2;
        end
        else
        begin
            f = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k = K3;
        end
        tmp = rotl(v_reg[0], 5) + f + v_reg[4] + k + w_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            t_reg     <= '0;
            h_reg     <= IV;
        end
        else
        begin
            case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        v_reg     <= h_reg;
                        w_reg     <= blk;
                        t_reg     <= '0;
                        state_reg <= R_RUN;
                    end
                    else if (init)
                    begin
                        h_reg <= IV;
                    end
                end
                R_RUN:
                begin
                    v_reg[0] <= tmp;
                    v_reg[1] <= v_reg[0];
                    v_reg[2] <= rotl(v_reg[1], 30);
                    v_reg[3] <= v_reg[2];
                    v_reg[4] <= v_reg[3];
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i + 1];
                    end
                    w_reg[15] <= wn;
                    t_reg     <= t_reg + 7'd1;
                    if (t_reg == 7'(ROUNDS - 1))
                    begin
                        state_reg <= R_ADD;
                    end
                end
                R_ADD:
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    state_reg <= R_IDLE;
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != R_IDLE);
    assign hash = h_reg;

    `ASSERT_IMPL(a_last_round, (state_reg == R_RUN && t_reg == 7'(ROUNDS - 1)) |=> (state_reg == R_ADD))
    `ASSERT_IMPL(a_add_once, (state_reg == R_ADD) |=> (state_reg == R_IDLE))
    `ASSERT_NEVER(a_round_range, state_reg == R_RUN && t_reg > 7'(ROUNDS - 1))
endmodule
